[design/clbs_pkg.sv]
// shared types, codes and constants for the character lcd bus sequencer
package clbs_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_INSTR_WRITE = 2'd0;
    localparam logic [1:0] CMD_DATA_WRITE  = 2'd1;
    localparam logic [1:0] CMD_DATA_READ   = 2'd2;
    localparam logic [1:0] CMD_BUS_SAMPLE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WRITE_STROBE = 2'd0;
    localparam logic [1:0] KIND_READ_STROBE  = 2'd1;
    localparam logic [1:0] KIND_DUMMY_STROBE = 2'd2;
    localparam logic [1:0] KIND_COMPLETE     = 2'd3;

    // sequencer phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_READ_FULL = 3'd1;
    localparam logic [2:0] PH_READ_HI   = 3'd2;
    localparam logic [2:0] PH_READ_LO   = 3'd3;
    localparam logic [2:0] PH_BUSY      = 3'd4;

    localparam int          BUSY_BIT_POS = 7;
    localparam logic [7:0]  HI_NIBBLE    = 8'hF0;
    localparam int          MAX_RESULTS  = 3;
    localparam int          RES_IDX_W    = $clog2(MAX_RESULTS);
    localparam int          RES_CNT_W    = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic [7:0] bus_in;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       reg_select;
        logic       read_not_write;
        logic [7:0] bus_out;
        logic [7:0] read_data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [2:0] phase;
        logic       op_is_read;
        logic [7:0] rd_byte;
    } t_seq_state;

    // what one decoded item produces
    typedef struct packed {
        logic [RES_CNT_W-1:0]          count;
        t_result [MAX_RESULTS-1:0]     res;
        t_seq_state                    next_state;
    } t_decode;

endpackage

[design/clbs_item_if.sv]
// input item channel: command, write byte and sampled bus pins
interface clbs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic [7:0] bus_in;

    modport source (output valid, output cmd, output value, output bus_in, input ready);
    modport sink   (input valid, input cmd, input value, input bus_in, output ready);
endinterface

[design/clbs_res_if.sv]
// result item channel: one bus event or completion per item
interface clbs_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       reg_select;
    logic       read_not_write;
    logic [7:0] bus_out;
    logic [7:0] read_data;
    logic       last;

    modport source (output valid, output kind, output reg_select, output read_not_write,
                    output bus_out, output read_data, output last, input ready);
    modport sink   (input valid, input kind, input reg_select, input read_not_write,
                    input bus_out, input read_data, input last, output ready);
endinterface

[design/char_lcd_bus_sequencer_core.sv]
// top level of the character lcd bus sequencer: input register, decode, result register
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+----------------------------------------------
//  i_item     | in  | valid / ready  | cmd, value, bus_in
//  o_res      | out | valid / ready  | kind, reg_select, read_not_write, bus_out,
//             |     |                | read_data, last
//  i_cfg_*    | in  | write enable   | four_bit_mode (1 bit)
//
//  an item waits in the input register and is decoded into the result register
//  once that register is free; the result register holds up to three events that
//  leave one per cycle while o_res.ready is high.
//  items that cause a single event flow at one item per cycle when o_res does not stall.
//  reset (synchronous, active low) returns the sequencer to idle with 4-bit mode on.
//  a stall on o_res backs up into the input register and then into i_item.ready.
module char_lcd_bus_sequencer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clbs_item_if.sink            i_item,
    clbs_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data
);

    // configuration
    logic r_four_bit;

    // input register
    logic            r_in_valid;
    clbs_pkg::t_item r_in;
    clbs_pkg::t_item item_now;

    // sequencer state
    clbs_pkg::t_seq_state r_state;

    // result register: events of the item being delivered
    logic                                      r_res_valid;
    clbs_pkg::t_result [clbs_pkg::MAX_RESULTS-1:0] r_res;
    logic [clbs_pkg::RES_IDX_W-1:0]            r_idx;
    logic [clbs_pkg::RES_IDX_W-1:0]            n_idx;

    clbs_pkg::t_decode dec;
    clbs_pkg::t_result cur_res;

    logic res_pop;
    logic res_free;
    logic dec_go;
    logic in_take;

    assign cur_res  = r_res[r_idx];
    assign res_pop  = r_res_valid && o_res.ready;
    // the result register frees up when empty or when its final event leaves now
    assign res_free = !r_res_valid || (res_pop && cur_res.last);
    assign dec_go   = r_in_valid && res_free;

    // input register takes a new item when empty or when its item moves on
    assign i_item.ready = !r_in_valid || dec_go;
    assign in_take      = i_item.valid && i_item.ready;

    assign item_now.cmd    = i_item.cmd;
    assign item_now.value  = i_item.value;
    assign item_now.bus_in = i_item.bus_in;

    assign n_idx = r_idx + clbs_pkg::RES_IDX_W'(1);

    clbs_decode u_decode (
        .i_item     (r_in),
        .i_state    (r_state),
        .i_four_bit (r_four_bit),
        .o_dec      (dec)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b1;
        end else if (i_cfg_we) begin
            r_four_bit <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= item_now;
        end
    end

    // phase state advances as each item is decoded, in arrival order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= clbs_pkg::PH_IDLE;
            r_state.op_is_read <= 1'b0;
            r_state.rd_byte    <= '0;
        end else if (dec_go) begin
            r_state <= dec.next_state;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_idx       <= '0;
        end else if (dec_go) begin
            // an ignored item leaves the register empty
            r_res_valid <= (dec.count != '0);
            r_idx       <= '0;
        end else if (res_pop && cur_res.last) begin
            r_res_valid <= 1'b0;
            r_idx       <= '0;
        end else if (res_pop) begin
            r_idx <= n_idx;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (dec_go) begin
            r_res <= dec.res;
        end
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.kind           = cur_res.kind;
    assign o_res.reg_select     = cur_res.reg_select;
    assign o_res.read_not_write = cur_res.read_not_write;
    assign o_res.bus_out        = cur_res.bus_out;
    assign o_res.read_data      = cur_res.read_data;
    assign o_res.last           = cur_res.last;

endmodule

[design/clbs_decode.sv]
// phase decoder: turns one item and the current phase into bus events
module clbs_decode (
    input  clbs_pkg::t_item      i_item,
    input  clbs_pkg::t_seq_state i_state,
    input  logic                 i_four_bit,
    output clbs_pkg::t_decode    o_dec
);

    clbs_pkg::t_decode dec;
    clbs_pkg::t_result poll_res;
    clbs_pkg::t_result tail_res;

    always_comb begin
        poll_res                = '0;
        poll_res.kind           = clbs_pkg::KIND_READ_STROBE;
        poll_res.read_not_write = 1'b1;

        tail_res        = '0;
        dec             = '0;
        dec.next_state  = i_state;

        if (i_item.cmd != clbs_pkg::CMD_BUS_SAMPLE) begin
            if (i_state.phase == clbs_pkg::PH_IDLE) begin
                if (i_item.cmd == clbs_pkg::CMD_DATA_READ) begin
                    dec.next_state.op_is_read     = 1'b1;
                    dec.next_state.rd_byte        = '0;
                    dec.next_state.phase          = i_four_bit ? clbs_pkg::PH_READ_HI
                                                               : clbs_pkg::PH_READ_FULL;
                    dec.res[0].kind               = clbs_pkg::KIND_READ_STROBE;
                    dec.res[0].reg_select         = 1'b1;
                    dec.res[0].read_not_write     = 1'b1;
                    dec.count                     = clbs_pkg::RES_CNT_W'(1);
                end else begin
                    dec.next_state.op_is_read = 1'b0;
                    dec.next_state.phase      = clbs_pkg::PH_BUSY;
                    dec.res[0].kind           = clbs_pkg::KIND_WRITE_STROBE;
                    dec.res[0].reg_select     = i_item.cmd[0];
                    if (i_four_bit) begin
                        dec.res[0].bus_out    = i_item.value & clbs_pkg::HI_NIBBLE;
                        dec.res[1].kind       = clbs_pkg::KIND_WRITE_STROBE;
                        dec.res[1].reg_select = i_item.cmd[0];
                        dec.res[1].bus_out    = {i_item.value[3:0], 4'd0};
                        dec.res[2]            = poll_res;
                        dec.count             = clbs_pkg::RES_CNT_W'(3);
                    end else begin
                        dec.res[0].bus_out    = i_item.value;
                        dec.res[1]            = poll_res;
                        dec.count             = clbs_pkg::RES_CNT_W'(2);
                    end
                end
            end
        end else begin
            unique case (i_state.phase)
                clbs_pkg::PH_READ_FULL: begin
                    dec.next_state.rd_byte = i_item.bus_in;
                    dec.next_state.phase   = clbs_pkg::PH_BUSY;
                    dec.res[0]             = poll_res;
                    dec.count              = clbs_pkg::RES_CNT_W'(1);
                end
                clbs_pkg::PH_READ_HI: begin
                    dec.next_state.rd_byte    = i_item.bus_in & clbs_pkg::HI_NIBBLE;
                    dec.next_state.phase      = clbs_pkg::PH_READ_LO;
                    dec.res[0].kind           = clbs_pkg::KIND_READ_STROBE;
                    dec.res[0].reg_select     = 1'b1;
                    dec.res[0].read_not_write = 1'b1;
                    dec.count                 = clbs_pkg::RES_CNT_W'(1);
                end
                clbs_pkg::PH_READ_LO: begin
                    dec.next_state.rd_byte = {i_state.rd_byte[7:4], i_item.bus_in[7:4]};
                    dec.next_state.phase   = clbs_pkg::PH_BUSY;
                    dec.res[0]             = poll_res;
                    dec.count              = clbs_pkg::RES_CNT_W'(1);
                end
                clbs_pkg::PH_BUSY: begin
                    // busy flag set: poll again, otherwise finish
                    if (i_item.bus_in[clbs_pkg::BUSY_BIT_POS]) begin
                        tail_res = poll_res;
                    end else begin
                        tail_res.kind      = clbs_pkg::KIND_COMPLETE;
                        tail_res.read_data = i_state.op_is_read ? i_state.rd_byte : 8'd0;
                        dec.next_state.phase = clbs_pkg::PH_IDLE;
                    end
                    if (i_four_bit) begin
                        dec.res[0].kind           = clbs_pkg::KIND_DUMMY_STROBE;
                        dec.res[0].read_not_write = 1'b1;
                        dec.res[1]                = tail_res;
                        dec.count                 = clbs_pkg::RES_CNT_W'(2);
                    end else begin
                        dec.res[0]                = tail_res;
                        dec.count                 = clbs_pkg::RES_CNT_W'(1);
                    end
                end
                default: begin
                    dec.count = '0;
                end
            endcase
        end

        // mark the final event of the run
        for (int k = 0; k < clbs_pkg::MAX_RESULTS; k++) begin
            dec.res[k].last = (dec.count == clbs_pkg::RES_CNT_W'(k + 1));
        end

        o_dec = dec;
    end

endmodule

[test/testbench.sv]
// self-checking testbench for the character lcd bus sequencer core
`timescale 1ns / 100ps

// tracks sequencer state from accepted items and holds the bus events still owed
class lcd_seq_scoreboard;
    bit                bit_pad_unused_guard;
    bit                four_bit;
    logic [2:0]        phase;
    bit                op_is_read;
    logic [7:0]        rd_byte;
    clbs_pkg::t_result bus_event_q[$];
    clbs_pkg::t_result step_q[$];
    int                errors;

    function new();
        bit_pad_unused_guard = 1'b0;
        four_bit   = 1'b1;
        phase      = clbs_pkg::PH_IDLE;
        op_is_read = 1'b0;
        rd_byte    = 8'h00;
        errors     = 0;
    endfunction

    function int pending();
        return bus_event_q.size();
    endfunction

    function void add_event(logic [1:0] kind, logic rs, logic rw, logic [7:0] bus,
                            logic [7:0] rd);
        clbs_pkg::t_result ev;
        ev.kind           = kind;
        ev.reg_select     = rs;
        ev.read_not_write = rw;
        ev.bus_out        = bus;
        ev.read_data      = rd;
        ev.last           = 1'b0;
        step_q.push_back(ev);
    endfunction

    function void start_poll();
        phase = clbs_pkg::PH_BUSY;
        add_event(clbs_pkg::KIND_READ_STROBE, 1'b0, 1'b1, 8'h00, 8'h00);
    endfunction

    // works out the bus events one accepted item causes
    function void note_item(clbs_pkg::t_item it);
        step_q.delete();
        if (it.cmd != clbs_pkg::CMD_BUS_SAMPLE) begin
            if (phase == clbs_pkg::PH_IDLE) begin
                if (it.cmd == clbs_pkg::CMD_DATA_READ) begin
                    op_is_read = 1'b1;
                    rd_byte    = 8'h00;
                    phase      = four_bit ? clbs_pkg::PH_READ_HI : clbs_pkg::PH_READ_FULL;
                    add_event(clbs_pkg::KIND_READ_STROBE, 1'b1, 1'b1, 8'h00, 8'h00);
                end else begin
                    op_is_read = 1'b0;
                    if (four_bit) begin
                        add_event(clbs_pkg::KIND_WRITE_STROBE, it.cmd[0], 1'b0,
                                  it.value & clbs_pkg::HI_NIBBLE, 8'h00);
                        add_event(clbs_pkg::KIND_WRITE_STROBE, it.cmd[0], 1'b0,
                                  {it.value[3:0], 4'h0}, 8'h00);
                    end else begin
                        add_event(clbs_pkg::KIND_WRITE_STROBE, it.cmd[0], 1'b0, it.value,
                                  8'h00);
                    end
                    start_poll();
                end
            end
        end else begin
            case (phase)
                clbs_pkg::PH_READ_FULL: begin
                    rd_byte = it.bus_in;
                    start_poll();
                end
                clbs_pkg::PH_READ_HI: begin
                    rd_byte = it.bus_in & clbs_pkg::HI_NIBBLE;
                    phase   = clbs_pkg::PH_READ_LO;
                    add_event(clbs_pkg::KIND_READ_STROBE, 1'b1, 1'b1, 8'h00, 8'h00);
                end
                clbs_pkg::PH_READ_LO: begin
                    rd_byte = {rd_byte[7:4], it.bus_in[7:4]};
                    start_poll();
                end
                clbs_pkg::PH_BUSY: begin
                    if (four_bit)
                        add_event(clbs_pkg::KIND_DUMMY_STROBE, 1'b0, 1'b1, 8'h00, 8'h00);
                    if (it.bus_in[clbs_pkg::BUSY_BIT_POS]) begin
                        add_event(clbs_pkg::KIND_READ_STROBE, 1'b0, 1'b1, 8'h00, 8'h00);
                    end else begin
                        add_event(clbs_pkg::KIND_COMPLETE, 1'b0, 1'b0, 8'h00,
                                  op_is_read ? rd_byte : 8'h00);
                        phase = clbs_pkg::PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            bus_event_q.push_back(step_q[i]);
    endfunction

    function void check_field(string field, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(clbs_pkg::t_result got);
        clbs_pkg::t_result exp_r;
        if (bus_event_q.size() == 0) begin
            $error("unexpected result: kind 0x%0h bus_out 0x%0h", got.kind, got.bus_out);
            errors++;
            return;
        end
        exp_r = bus_event_q.pop_front();
        check_field("kind", exp_r.kind, got.kind);
        check_field("reg_select", exp_r.reg_select, got.reg_select);
        check_field("read_not_write", exp_r.read_not_write, got.read_not_write);
        check_field("bus_out", exp_r.bus_out, got.bus_out);
        check_field("read_data", exp_r.read_data, got.read_data);
        check_field("last", exp_r.last, got.last);
    endfunction
endclass

module testbench;
    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_data;

    clbs_item_if item_if();
    clbs_res_if  res_if();

    lcd_seq_scoreboard sb;

    // idle percentages per side, changed by the stimulus between phases
    int send_idle_pct;
    int recv_idle_pct;
    // set once by the stimulus to ask the receiver for one long hold-off
    bit hold_req;

    char_lcd_bus_sequencer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or drops results
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random ready at the falling edge, plus one long hold-off on request
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 60;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else begin
                res_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result monitor: every accepted result goes against the oldest expectation
    always @(posedge i_clk) begin
        clbs_pkg::t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind           = res_if.kind;
            got.reg_select     = res_if.reg_select;
            got.read_not_write = res_if.read_not_write;
            got.bus_out        = res_if.bus_out;
            got.read_data      = res_if.read_data;
            got.last           = res_if.last;
            sb.check_result(got);
        end
    end

    // offers one item from a falling edge, with random idle cycles first,
    // and returns at the falling edge after it was accepted
    task automatic send_item(logic [1:0] cmd, logic [7:0] value, logic [7:0] bus);
        clbs_pkg::t_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge i_clk);
        end
        item_if.valid  = 1'b1;
        item_if.cmd    = cmd;
        item_if.value  = value;
        item_if.bus_in = bus;
        do @(posedge i_clk); while (!item_if.ready);
        it.cmd    = cmd;
        it.value  = value;
        it.bus_in = bus;
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    // sample item; the value field is don't-care so it gets noise
    task automatic send_sample(logic [7:0] bus);
        send_item(clbs_pkg::CMD_BUS_SAMPLE, 8'($urandom), bus);
    endtask

    // command item; the bus_in field is don't-care so it gets noise
    task automatic send_cmd(logic [1:0] cmd, logic [7:0] value);
        send_item(cmd, value, 8'($urandom));
    endtask

    // wait for every owed result, then a few idle cycles so nothing is left in flight
    task automatic drain();
        item_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_mode(bit four_bit);
        cfg_we   = 1'b1;
        cfg_data = four_bit;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        sb.four_bit = four_bit;
    endtask

    // mostly well-formed traffic: a command when idle, samples while busy,
    // with a tenth of the items out of place
    task automatic send_random_item();
        logic [1:0] cmd;
        logic [7:0] value;
        logic [7:0] bus;
        value = 8'($urandom);
        bus   = 8'($urandom);
        if (sb.phase == clbs_pkg::PH_IDLE && $urandom_range(99) < 90) begin
            case ($urandom_range(2))
                0: cmd = clbs_pkg::CMD_INSTR_WRITE;
                1: cmd = clbs_pkg::CMD_DATA_WRITE;
                default: cmd = clbs_pkg::CMD_DATA_READ;
            endcase
        end else if (sb.phase == clbs_pkg::PH_IDLE) begin
            cmd = clbs_pkg::CMD_BUS_SAMPLE;
        end else if ($urandom_range(99) < 90) begin
            cmd = clbs_pkg::CMD_BUS_SAMPLE;
            // keep busy polls short so most operations complete
            if (sb.phase == clbs_pkg::PH_BUSY)
                bus[clbs_pkg::BUSY_BIT_POS] = ($urandom_range(99) < 35);
        end else begin
            cmd = 2'($urandom_range(2));
        end
        send_item(cmd, value, bus);
    endtask

    initial begin : stimulus
        sb = new();
        hold_req       = 1'b0;
        send_idle_pct  = 24;
        recv_idle_pct  = 80;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 1'b0;
        item_if.valid  = 1'b0;
        item_if.cmd    = clbs_pkg::CMD_INSTR_WRITE;
        item_if.value  = 8'h00;
        item_if.bus_in = 8'h00;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, 4-bit mode out of reset
        send_sample(8'hFF);                     // sample while idle is dropped
        send_cmd(clbs_pkg::CMD_INSTR_WRITE, 8'hFF);
        send_cmd(clbs_pkg::CMD_DATA_WRITE, 8'h00);  // command while busy is dropped
        send_sample(8'h80);                     // still busy
        send_sample(8'h7F);                     // busy clear
        send_cmd(clbs_pkg::CMD_DATA_WRITE, 8'hA5);
        send_sample(8'h00);
        send_cmd(clbs_pkg::CMD_DATA_READ, 8'h00);
        send_sample(8'hAF);                     // high nibble
        send_sample(8'h5F);                     // low nibble from pins 7:4
        send_sample(8'h00);

        // directed, 8-bit mode
        drain();
        write_mode(1'b0);
        send_cmd(clbs_pkg::CMD_INSTR_WRITE, 8'h00);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_cmd(clbs_pkg::CMD_DATA_READ, 8'hFF);
        send_sample(8'hC3);
        send_sample(8'h01);

        // mode flipped while a whole-byte read waits for its sample
        send_cmd(clbs_pkg::CMD_DATA_READ, 8'h3C);
        drain();
        write_mode(1'b1);
        send_sample(8'h3C);
        send_sample(8'h00);                     // poll now adds the dummy strobe

        // mode flipped while a nibble read waits for its high nibble
        send_cmd(clbs_pkg::CMD_DATA_READ, 8'h00);
        drain();
        write_mode(1'b0);
        send_sample(8'hB0);
        send_sample(8'h70);
        send_sample(8'h00);

        // random, sender idles lightly and receiver heavily, 4-bit mode
        drain();
        write_mode(1'b1);
        repeat (36) send_random_item();

        // random, roles swapped, 8-bit mode
        drain();
        write_mode(1'b0);
        send_idle_pct = 80;
        recv_idle_pct = 24;
        repeat (36) send_random_item();

        // random at full rate, 4-bit mode, with one long receiver hold-off
        // so the result register and input register back up
        drain();
        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (36) send_random_item();

        item_if.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

[files.f]
design/clbs_pkg.sv
design/clbs_item_if.sv
design/clbs_res_if.sv
design/clbs_decode.sv
design/char_lcd_bus_sequencer_core.sv
test/testbench.sv
